// ===== rtl/sspe_pkg.sv =====
// Package: widths, constants and types shared by the share evaluator files.
package sspe_pkg;

  localparam int MaxCoeffs = 32;
  localparam int SlotW     = 5;
  localparam int CountW    = 6;
  localparam int LimbW     = 64;
  localparam int AccW      = 288;
  localparam int RedSteps  = 13;
  localparam int StepW     = 4;

  localparam logic [AccW-1:0] OrderL =
    {32'h0, 32'h10000000, 32'h0, 32'h0, 32'h0,
     32'h14def9de, 32'ha2f79cd6, 32'h5812631a, 32'h5cf5d3ed};

  localparam logic CmdLoad = 1'b0;
  localparam logic CmdEval = 1'b1;

  typedef struct packed {
    logic       start;
    logic [7:0] j;
    logic [LimbW-1:0] limb;
    logic [1:0] limb_idx;
    logic       limb_valid;
    logic       last_limb;
  } sspe_ctl_t;

endpackage

// ===== rtl/sspe_mac_unit.sv =====
// Shared multiply-add-reduce datapath: acc = (acc*j + coeff) mod L, one coefficient per pass.
module sspe_mac_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  sspe_pkg::sspe_ctl_t       ctl,
  output logic                      done,
  output logic [sspe_pkg::AccW-1:0] acc
);
  import sspe_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_MUL, S_LOAD, S_ADD, S_RED} state_t;

  state_t            state;
  logic [AccW-1:0]   coeff;
  logic [StepW-1:0]  step;
  logic [3:0]        word;
  logic [7:0]        j;
  logic [AccW-1:0]   prod;
  logic [31:0]       carry;
  logic [AccW-1:0]   sub_t;
  logic [AccW:0]     diff;
  logic [AccW:0]     sum;
  logic [39:0]       mprod;

  assign mprod = {8'd0, acc[word*32 +: 32]} * {32'd0, j} + {8'd0, carry};
  assign sum   = {1'b0, acc} + {1'b0, coeff};
  assign sub_t = OrderL << step;
  assign diff  = {1'b0, acc} - {1'b0, sub_t};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      acc   <= '0;
      done  <= 1'b0;
    end else begin
      done <= (state == S_RED) && (step == '0);
      case (state)
        S_IDLE: begin
          if (ctl.start) begin
            acc   <= '0;
            j     <= ctl.j;
            state <= S_LOAD;
          end
        end
        S_MUL: begin
          prod[word*32 +: 32] <= mprod[31:0];
          carry <= mprod[39:32] == 8'd0 ? 32'd0 : {24'd0, mprod[39:32]};
          if (word == 4'd8) state <= S_ADD;
          else word <= word + 4'd1;
        end
        S_ADD: begin
          acc   <= sum[AccW-1:0];
          step  <= StepW'(RedSteps - 1);
          state <= S_RED;
        end
        S_RED: begin
          if (!diff[AccW]) acc <= diff[AccW-1:0];
          if (step == '0) state <= S_LOAD;
          else step <= step - 1'b1;
        end
        S_LOAD: begin
          if (ctl.start) begin
            acc <= '0;
            j   <= ctl.j;
          end else if (ctl.limb_valid) begin
            if (ctl.limb_idx == 2'd0) coeff <= {{(AccW-LimbW){1'b0}}, ctl.limb};
            else coeff[ctl.limb_idx*64 +: 64] <= ctl.limb;
            if (ctl.last_limb) begin
              word  <= '0;
              carry <= '0;
              state <= S_MUL;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
      if (state == S_MUL && word == 4'd8) acc <= {mprod[31:0], prod[255:0]};
    end
  end
endmodule

// ===== rtl/shamir_share_poly_eval.sv =====
// Top level: coefficient memory, evaluation sequencer and output register.
//
//  channel   dir  fields
//  s_axis    in   tdata {share_index, limb_value, limb_select, coeff_slot}, tuser command
//  m_axis    out  tdata {out_limb, out_limb_select, out_index}, tlast out_last
//  cfg       in   coeff_count, 6 bits
//
// A load writes one limb to the coefficient memory. An evaluation has one start step and
// then, per coefficient, 4 memory reads through a registered read port, 9 word multiplies
// on the 32x8 multiplier, an add, 13 reduce steps and a handoff, then 4 output items.
// Reset: synchronous, count returns to 1. Output stalls hold the sequencer.
module shamir_share_poly_eval (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,  // coeff_slot, limb_select, limb_value, share_index
  input  logic        s_axis_tuser,  // command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,  // out_index, out_limb_select, out_limb, zero pad
  output logic        m_axis_tlast,  // out_last
  input  logic        cfg_we,
  input  logic [5:0]  cfg_wdata
);
  import sspe_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_START, S_RD, S_WAIT, S_OUT} state_t;

  state_t           state;
  logic [LimbW-1:0] mem [0:MaxCoeffs*4-1];
  logic [LimbW-1:0] rd_data;
  logic [6:0]       rd_addr;
  logic [CountW-1:0] count;
  logic [SlotW-1:0] t;
  logic [1:0]       k;
  logic             rd_pend;
  logic [1:0]       rd_k;
  logic [7:0]       j;
  logic [1:0]       ok;
  sspe_ctl_t        ctl;
  logic             mac_done;
  logic [AccW-1:0]  acc;
  logic             in_acc;
  logic [SlotW-1:0] n_top;

  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == S_IDLE);
  assign n_top = (count == '0) ? '0 :
                 (count > CountW'(MaxCoeffs)) ? SlotW'(MaxCoeffs - 1) : SlotW'(count - 1'b1);
  assign rd_addr = {t, k};

  always_ff @(posedge clk) begin
    if (in_acc && s_axis_tuser == CmdLoad)
      mem[{s_axis_tdata[4:0], s_axis_tdata[6:5]}] <= s_axis_tdata[70:7];
    rd_data <= mem[rd_addr];
  end

  assign ctl.start      = (state == S_START);
  assign ctl.j          = j;
  assign ctl.limb       = rd_data;
  assign ctl.limb_idx   = rd_k;
  assign ctl.limb_valid = rd_pend;
  assign ctl.last_limb  = (rd_k == 2'd3);

  sspe_mac_unit u_mac (.clk(clk), .rst(rst), .ctl(ctl), .done(mac_done), .acc(acc));

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 6'd1;
      state <= S_IDLE;
      m_axis_tvalid <= 1'b0;
      rd_pend <= 1'b0;
    end else begin
      if (cfg_we) count <= cfg_wdata;
      rd_pend <= (state == S_RD);
      case (state)
        S_IDLE: if (in_acc && s_axis_tuser == CmdEval) begin
          j     <= s_axis_tdata[78:71];
          t     <= n_top;
          k     <= '0;
          state <= S_START;
        end
        S_START: state <= S_RD;
        S_RD: begin
          rd_k    <= k;
          k       <= k + 2'd1;
          if (k == 2'd3) state <= S_WAIT;
        end
        S_WAIT: if (mac_done) begin
          if (t == '0) begin
            ok <= '0;
            m_axis_tvalid <= 1'b1;
            state <= S_OUT;
          end else begin
            t <= t - 1'b1;
            state <= S_RD;
          end
        end
        S_OUT: if (m_axis_tready) begin
          ok <= ok + 2'd1;
          if (ok == 2'd3) begin
            m_axis_tvalid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tdata = {6'd0, acc[ok*64 +: 64], ok, j};
  assign m_axis_tlast = (ok == 2'd3);

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !m_axis_tvalid) else $error("ready while output busy");
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata)) else $error("output moved");
  a_last_end: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && m_axis_tlast |=> !m_axis_tvalid)
    else $error("valid after last");
endmodule
